>>> rtl/core/idea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idea_pkg
// Shared types, constants and arithmetic helpers of the block cipher core.
// ----------------------------------------------------------------------------
package idea_pkg;

    localparam int WORD_W      = 16;
    localparam int ADDR_W      = 6;
    localparam int STORE_DEPTH = 52;
    localparam int KEY_W       = 128;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int BLK_W       = 4 * WORD_W;
    localparam int INV_STEPS   = 15;
    localparam int INV_CNT_W   = 4;
    localparam int ROT_BITS    = 25;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd2;

    typedef enum logic [3:0] {
        ST_BLD_INIT,
        ST_BLD_WORD,
        ST_INV_SQ,
        ST_INV_MUL,
        ST_INV_WR,
        ST_IDLE,
        ST_RND_A,
        ST_RND_B,
        ST_RND_C,
        ST_OUT_MUL,
        ST_OUT_ADD
    } state_t;

    typedef enum logic [1:0] {
        KOP_COPY,
        KOP_NEG,
        KOP_INV
    } key_op_t;

    typedef enum logic [1:0] {
        WR_COPY,
        WR_NEG,
        WR_ACC
    } wr_sel_t;

    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_MUL,
        STEP_ADD_E,
        STEP_MIX,
        STEP_OUT_MUL
    } step_t;

    typedef struct packed {
        logic              key_load;
        logic              key_rot;
        logic [2:0]        word_sel;
        logic              acc_load;
        logic              acc_sq;
        logic              acc_mul;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        wr_sel_t           wr_sel;
        logic [ADDR_W-1:0] rd_addr0;
        logic [ADDR_W-1:0] rd_addr1;
        logic              blk_load;
        step_t             step;
        logic              out_load;
    } cmd_t;

    typedef struct packed {
        logic decrypt;
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        key_op_t           op;
    } dest_t;

    // multiplication mod 65537, zero stands for 65536
    function automatic logic [WORD_W-1:0] mul_mod(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [2*WORD_W-1:0] p;
        logic [WORD_W-1:0]   lo;
        logic [WORD_W-1:0]   hi;
        logic [WORD_W-1:0]   r;
        p  = (2*WORD_W)'(a) * (2*WORD_W)'(b);
        lo = p[WORD_W-1:0];
        hi = p[2*WORD_W-1:WORD_W];
        if (a == '0)
            r = WORD_W'(1) - b;
        else if (b == '0)
            r = WORD_W'(1) - a;
        else
            r = lo - hi + WORD_W'(lo < hi);
        return r;
    endfunction

    // where an expanded key word lands in the store and how it is transformed
    function automatic dest_t key_dest(input logic              decrypt,
                                       input logic [ADDR_W-1:0] e,
                                       input logic [2:0]        o,
                                       input logic [ADDR_W-1:0] pbase);
        dest_t d;
        logic  last;
        last   = (pbase == 6'd6);
        d.addr = e;
        d.op   = KOP_COPY;
        if (decrypt)
        begin
            if (e < 6'd4)
            begin
                d.addr = pbase + {4'd0, e[1:0]};
                d.op   = (e[1:0] == 2'd0 || e[1:0] == 2'd3) ? KOP_INV : KOP_NEG;
            end
            else
            begin
                case (o)
                    3'd0:
                    begin
                        d.addr = pbase - 6'd2;
                        d.op   = KOP_COPY;
                    end
                    3'd1:
                    begin
                        d.addr = pbase - 6'd1;
                        d.op   = KOP_COPY;
                    end
                    3'd2:
                    begin
                        d.addr = pbase - 6'd6;
                        d.op   = KOP_INV;
                    end
                    3'd3:
                    begin
                        // additive pair stays in place only for the last group
                        d.addr = last ? pbase - 6'd5 : pbase - 6'd4;
                        d.op   = KOP_NEG;
                    end
                    3'd4:
                    begin
                        d.addr = last ? pbase - 6'd4 : pbase - 6'd5;
                        d.op   = KOP_NEG;
                    end
                    default:
                    begin
                        d.addr = pbase - 6'd3;
                        d.op   = KOP_INV;
                    end
                endcase
            end
        end
        return d;
    endfunction

endpackage

>>> rtl/core/idea_block_cipher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idea_block_cipher_core
// IDEA block cipher on 64-bit blocks with a 128-bit key, encrypt or decrypt.
// ----------------------------------------------------------------------------
// usage:
// - s_axis carries one 64-bit block per beat, m_axis returns the processed
//   block. cfg_wr_en/cfg_index/cfg_data write key low (0), key high (1) and
//   mode (2, bit 0: 1 decrypt, 0 encrypt).
// - a block runs three steps per round on the mod 65537 multipliers (two
//   subkeys read from the store per step), then two output transform
//   steps; the next block is accepted only once its last step is done.
// - after reset and after every register write the subkey store is rebuilt
//   and s_axis_tready stays low until the rebuild is done; in decrypt mode
//   each inverse is 15 square and multiply steps on the shared multiplier.
// - reset key is all zero in decrypt mode.
// - the result waits in an output register; if the receiver stalls, the
//   next block is taken and runs, and holds at its last step until the
//   register frees.
// ----------------------------------------------------------------------------
module idea_block_cipher_core
#(
    parameter int ROUND_COUNT = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [idea_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [idea_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // block_word_0, block_word_1, block_word_2, block_word_3
    input  logic [idea_pkg::BLK_W-1:0]      s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // result_word_0, result_word_1, result_word_2, result_word_3
    output logic [idea_pkg::BLK_W-1:0]      m_axis_tdata
);

    idea_pkg::cmd_t    cmd;
    idea_pkg::status_t status;

    idea_ctrl #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    idea_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .blk_in    (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .blk_out   (m_axis_tdata)
    );

endmodule

>>> rtl/core/idea_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idea_dpath
// Config registers, key rotor, modular inverse accumulator, subkey memory
// and the round datapath with two mod 65537 multipliers.
// ----------------------------------------------------------------------------
module idea_dpath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [idea_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [idea_pkg::CFG_W-1:0]      cfg_data,
    input  logic [idea_pkg::BLK_W-1:0]      blk_in,
    input  idea_pkg::cmd_t                  cmd,
    output idea_pkg::status_t               status,
    output logic [idea_pkg::BLK_W-1:0]      blk_out
);

    localparam int W = idea_pkg::WORD_W;

    logic [idea_pkg::CFG_W-1:0] key_low_reg;
    logic [idea_pkg::CFG_W-1:0] key_high_reg;
    logic                       mode_reg;
    logic [idea_pkg::KEY_W-1:0] krot_reg;
    logic [W-1:0]               acc_reg;
    logic [W-1:0]               base_reg;
    logic [W-1:0]               store [idea_pkg::STORE_DEPTH];
    logic [W-1:0]               rd0_reg;
    logic [W-1:0]               rd1_reg;
    logic [W-1:0]               x1_reg, x2_reg, x3_reg, x4_reg;
    logic [W-1:0]               a_reg, c_reg, d_reg, e_reg;
    logic [idea_pkg::BLK_W-1:0] out_reg;

    logic [W-1:0] krot_word;
    logic [W-1:0] wr_data;
    logic [W-1:0] mula_x, mula_y, mula_res;
    logic [W-1:0] mulb_res;
    logic [W-1:0] c_now, b_now, t_now, g_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            mode_reg     <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                idea_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                idea_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                idea_pkg::REG_MODE:     mode_reg     <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    assign status.decrypt = mode_reg;

    // word 0 of the key sits at the top of the rotor
    assign krot_word = krot_reg[{~cmd.word_sel, 4'b0000} +: W];

    always_comb
    begin
        case (cmd.wr_sel)
            idea_pkg::WR_NEG: wr_data = W'(0) - krot_word;
            idea_pkg::WR_ACC: wr_data = acc_reg;
            default:          wr_data = krot_word;
        endcase
    end

    assign c_now = x3_reg + rd0_reg;
    assign b_now = x2_reg + rd0_reg;
    assign t_now = (b_now ^ d_reg) + e_reg;

    always_comb
    begin
        case (cmd.step)
            idea_pkg::STEP_MUL, idea_pkg::STEP_OUT_MUL:
            begin
                mula_x = x1_reg;
                mula_y = rd0_reg;
            end
            idea_pkg::STEP_ADD_E:
            begin
                mula_x = a_reg ^ c_now;
                mula_y = rd1_reg;
            end
            idea_pkg::STEP_MIX:
            begin
                mula_x = t_now;
                mula_y = rd1_reg;
            end
            default:
            begin
                mula_x = acc_reg;
                mula_y = cmd.acc_sq ? acc_reg : base_reg;
            end
        endcase
    end

    assign mula_res = idea_pkg::mul_mod(mula_x, mula_y);
    assign mulb_res = idea_pkg::mul_mod(x4_reg, rd1_reg);
    assign g_now    = e_reg + mula_res;

    always_ff @(posedge clk)
    begin
        if (cmd.key_load)
            krot_reg <= {key_low_reg[15:0],  key_low_reg[31:16],
                         key_low_reg[47:32], key_low_reg[63:48],
                         key_high_reg[15:0], key_high_reg[31:16],
                         key_high_reg[47:32], key_high_reg[63:48]};
        else if (cmd.key_rot)
            krot_reg <= {krot_reg[idea_pkg::KEY_W-idea_pkg::ROT_BITS-1:0],
                         krot_reg[idea_pkg::KEY_W-1:idea_pkg::KEY_W-idea_pkg::ROT_BITS]};

        // inverse by x^65535: square then multiply by the base
        if (cmd.acc_load)
        begin
            acc_reg  <= krot_word;
            base_reg <= krot_word;
        end
        else if (cmd.acc_sq || cmd.acc_mul)
            acc_reg <= mula_res;

        if (cmd.wr_en)
            store[cmd.wr_addr] <= wr_data;
        rd0_reg <= store[cmd.rd_addr0];
        rd1_reg <= store[cmd.rd_addr1];

        if (cmd.blk_load)
        begin
            x1_reg <= blk_in[W-1:0];
            x2_reg <= blk_in[2*W-1:W];
            x3_reg <= blk_in[3*W-1:2*W];
            x4_reg <= blk_in[4*W-1:3*W];
        end
        else if (cmd.step == idea_pkg::STEP_MIX)
        begin
            x1_reg <= a_reg ^ mula_res;
            x2_reg <= c_reg ^ mula_res;
            x3_reg <= b_now ^ g_now;
            x4_reg <= d_reg ^ g_now;
        end

        if (cmd.step == idea_pkg::STEP_MUL || cmd.step == idea_pkg::STEP_OUT_MUL)
        begin
            a_reg <= mula_res;
            d_reg <= mulb_res;
        end
        if (cmd.step == idea_pkg::STEP_ADD_E)
        begin
            c_reg <= c_now;
            e_reg <= mula_res;
        end

        // output transform swaps the middle words
        if (cmd.out_load)
            out_reg <= {d_reg, x2_reg + rd1_reg, x3_reg + rd0_reg, a_reg};
    end

    assign blk_out = out_reg;

endmodule

>>> rtl/core/idea_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idea_ctrl
// Sequencer for subkey schedule rebuild and for the round loop of one block.
// ----------------------------------------------------------------------------
module idea_ctrl
#(
    parameter int ROUND_COUNT = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  idea_pkg::status_t status,
    output idea_pkg::cmd_t    cmd
);

    localparam int A = idea_pkg::ADDR_W;
    localparam int RND_W = $clog2(ROUND_COUNT + 1);
    localparam logic [A-1:0] SCHED_LEN = A'(6 * ROUND_COUNT + 4);

    idea_pkg::state_t state_reg, state_next;

    logic [A-1:0]                    e_reg;
    logic [2:0]                      o_reg;
    logic [A-1:0]                    pbase_reg;
    logic [idea_pkg::INV_CNT_W-1:0]  inv_cnt_reg;
    logic [RND_W-1:0]                rnd_reg;
    logic [A-1:0]                    kbase_reg;
    logic                            out_valid_reg;

    idea_pkg::dest_t dest;
    logic            advance;
    logic            build_last;
    logic            inv_last;
    logic            rnd_last;
    logic            slot_free;
    logic            accept;
    logic [A-1:0]    kb6;

    assign dest       = idea_pkg::key_dest(status.decrypt, e_reg, o_reg, pbase_reg);
    assign advance    = (state_reg == idea_pkg::ST_BLD_WORD && dest.op != idea_pkg::KOP_INV)
                        || state_reg == idea_pkg::ST_INV_WR;
    assign build_last = (e_reg == SCHED_LEN - A'(1));
    assign inv_last   = (inv_cnt_reg == idea_pkg::INV_CNT_W'(idea_pkg::INV_STEPS - 1));
    assign rnd_last   = (rnd_reg == RND_W'(ROUND_COUNT - 1));
    assign slot_free  = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == idea_pkg::ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign kb6        = kbase_reg + A'(6);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            idea_pkg::ST_BLD_INIT: state_next = idea_pkg::ST_BLD_WORD;
            idea_pkg::ST_BLD_WORD:
            begin
                if (dest.op == idea_pkg::KOP_INV)
                    state_next = idea_pkg::ST_INV_SQ;
                else if (build_last)
                    state_next = idea_pkg::ST_IDLE;
            end
            idea_pkg::ST_INV_SQ:   state_next = idea_pkg::ST_INV_MUL;
            idea_pkg::ST_INV_MUL:
                state_next = inv_last ? idea_pkg::ST_INV_WR : idea_pkg::ST_INV_SQ;
            idea_pkg::ST_INV_WR:
                state_next = build_last ? idea_pkg::ST_IDLE : idea_pkg::ST_BLD_WORD;
            idea_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = idea_pkg::ST_RND_A;
            end
            idea_pkg::ST_RND_A:    state_next = idea_pkg::ST_RND_B;
            idea_pkg::ST_RND_B:    state_next = idea_pkg::ST_RND_C;
            idea_pkg::ST_RND_C:
                state_next = rnd_last ? idea_pkg::ST_OUT_MUL : idea_pkg::ST_RND_A;
            idea_pkg::ST_OUT_MUL:  state_next = idea_pkg::ST_OUT_ADD;
            idea_pkg::ST_OUT_ADD:
            begin
                if (slot_free)
                    state_next = idea_pkg::ST_IDLE;
            end
            default:               state_next = idea_pkg::ST_BLD_INIT;
        endcase
        // any register write rebuilds the schedule from scratch
        if (cfg_wr_en)
            state_next = idea_pkg::ST_BLD_INIT;
    end

    always_comb
    begin
        cmd          = '0;
        cmd.word_sel = e_reg[2:0];
        cmd.wr_addr  = dest.addr;
        cmd.wr_sel   = idea_pkg::WR_COPY;
        cmd.step     = idea_pkg::STEP_NONE;
        cmd.key_rot  = advance && (e_reg[2:0] == 3'd7);
        case (state_reg)
            idea_pkg::ST_BLD_INIT: cmd.key_load = 1'b1;
            idea_pkg::ST_BLD_WORD:
            begin
                if (dest.op == idea_pkg::KOP_INV)
                    cmd.acc_load = 1'b1;
                else
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = (dest.op == idea_pkg::KOP_NEG) ? idea_pkg::WR_NEG
                                                                : idea_pkg::WR_COPY;
                end
            end
            idea_pkg::ST_INV_SQ:   cmd.acc_sq = 1'b1;
            idea_pkg::ST_INV_MUL:  cmd.acc_mul = 1'b1;
            idea_pkg::ST_INV_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = idea_pkg::WR_ACC;
            end
            idea_pkg::ST_IDLE:
            begin
                cmd.blk_load = accept;
                cmd.rd_addr0 = A'(0);
                cmd.rd_addr1 = A'(3);
            end
            idea_pkg::ST_RND_A:
            begin
                cmd.step     = idea_pkg::STEP_MUL;
                cmd.rd_addr0 = kbase_reg + A'(2);
                cmd.rd_addr1 = kbase_reg + A'(4);
            end
            idea_pkg::ST_RND_B:
            begin
                cmd.step     = idea_pkg::STEP_ADD_E;
                cmd.rd_addr0 = kbase_reg + A'(1);
                cmd.rd_addr1 = kbase_reg + A'(5);
            end
            idea_pkg::ST_RND_C:
            begin
                cmd.step     = idea_pkg::STEP_MIX;
                cmd.rd_addr0 = kb6;
                cmd.rd_addr1 = kb6 + A'(3);
            end
            idea_pkg::ST_OUT_MUL:
            begin
                cmd.step     = idea_pkg::STEP_OUT_MUL;
                cmd.rd_addr0 = kbase_reg + A'(1);
                cmd.rd_addr1 = kbase_reg + A'(2);
            end
            idea_pkg::ST_OUT_ADD:
            begin
                cmd.rd_addr0 = kbase_reg + A'(1);
                cmd.rd_addr1 = kbase_reg + A'(2);
                cmd.out_load = slot_free;
            end
            default:               ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= idea_pkg::ST_BLD_INIT;
            e_reg         <= '0;
            o_reg         <= '0;
            pbase_reg     <= '0;
            inv_cnt_reg   <= '0;
            rnd_reg       <= '0;
            kbase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == idea_pkg::ST_BLD_INIT)
            begin
                e_reg     <= '0;
                o_reg     <= '0;
                pbase_reg <= SCHED_LEN - A'(4);
            end
            else if (advance && !build_last)
            begin
                e_reg <= e_reg + A'(1);
                if (e_reg >= A'(4))
                begin
                    if (o_reg == 3'd5)
                    begin
                        o_reg     <= '0;
                        pbase_reg <= pbase_reg - A'(6);
                    end
                    else
                        o_reg <= o_reg + 3'd1;
                end
            end

            if (state_reg == idea_pkg::ST_BLD_WORD)
                inv_cnt_reg <= '0;
            else if (state_reg == idea_pkg::ST_INV_MUL)
                inv_cnt_reg <= inv_cnt_reg + idea_pkg::INV_CNT_W'(1);

            if (accept)
            begin
                rnd_reg   <= '0;
                kbase_reg <= '0;
            end
            else if (state_reg == idea_pkg::ST_RND_C)
            begin
                kbase_reg <= kb6;
                if (!rnd_last)
                    rnd_reg <= rnd_reg + RND_W'(1);
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> state_reg == idea_pkg::ST_BLD_INIT)
        else $error("register write did not restart schedule build");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_wr_en) |=> state_reg == idea_pkg::ST_RND_A)
        else $error("accepted block did not start round one");

    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> cmd.wr_addr < SCHED_LEN)
        else $error("subkey write outside schedule");

    a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwrote a beat not yet taken");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the block cipher core. A local model expands the
// key into the subkey schedule (plain or inverted) and runs every accepted
// block through the rounds; each returned block is compared word by word
// with the oldest prediction. Keys and mode change between phases while the
// core is idle; both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import idea_pkg::*;

    localparam int ROUNDS   = 8;
    localparam int SCHED    = 6 * ROUNDS + 4;
    localparam int DRAIN_CY = 3 * ROUNDS + 12;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [BLK_W-1:0]     s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [BLK_W-1:0]     m_axis_tdata;

    idea_block_cipher_core #(.ROUND_COUNT(ROUNDS)) uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // block_word_0, block_word_1, block_word_2, block_word_3
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // result_word_0, result_word_1, result_word_2, result_word_3
        .m_axis_tdata  (m_axis_tdata)
    );

    // model copy of the registers and subkey schedule
    logic [63:0]       key_lo_m;
    logic [63:0]       key_hi_m;
    logic              decrypt_m;
    logic [WORD_W-1:0] subkeys [SCHED];

    logic [BLK_W-1:0]  cipher_q [$];
    int                errors;
    int                burst_left;
    bit                no_idle;
    int                hold_req;
    int                hold_seen;
    int                hold_cnt;
    int                rx_mode;
    int                rx_phase;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [15:0] mod_mul(input logic [15:0] a, input logic [15:0] b);
        logic [33:0] x;
        logic [33:0] y;
        x = (a == 16'd0) ? 34'd65536 : {18'd0, a};
        y = (b == 16'd0) ? 34'd65536 : {18'd0, b};
        return 16'((x * y) % 34'd65537);
    endfunction

    function automatic logic [15:0] mod_inv(input logic [15:0] v);
        logic [33:0] acc;
        logic [33:0] pw;
        int          e;
        if (v <= 16'd1)
            return v;
        acc = 34'd1;
        pw  = {18'd0, v};
        e   = 65535;
        while (e != 0)
        begin
            if (e & 1)
                acc = (acc * pw) % 34'd65537;
            pw = (pw * pw) % 34'd65537;
            e  = e >> 1;
        end
        return acc[15:0];
    endfunction

    task automatic rebuild_subkeys();
        logic [15:0] ek [SCHED];
        logic [15:0] dk [SCHED];
        int          j;
        int          base;
        int          i;
        int          q;
        int          p;
        int          r;
        base = 0;
        i    = 0;
        for (j = 0; j < SCHED; j++)
        begin
            ek[j] = '0;
            dk[j] = '0;
        end
        for (j = 0; j < 4; j++)
        begin
            ek[j]     = key_lo_m[16*j +: 16];
            ek[j + 4] = key_hi_m[16*j +: 16];
        end
        for (j = 8; j < SCHED; j++)
        begin
            i++;
            ek[base + i + 7] = (ek[base + (i & 7)] << 9) | (ek[base + ((i + 1) & 7)] >> 7);
            base += i & 8;
            i &= 7;
        end
        if (!decrypt_m)
        begin
            for (j = 0; j < SCHED; j++)
                subkeys[j] = ek[j];
        end
        else
        begin
            p = SCHED;
            p--; dk[p] = mod_inv(ek[3]);
            p--; dk[p] = -ek[2];
            p--; dk[p] = -ek[1];
            p--; dk[p] = mod_inv(ek[0]);
            q = 4;
            for (r = 1; r <= ROUNDS; r++)
            begin
                p--; dk[p] = ek[q + 1];
                p--; dk[p] = ek[q];
                p--; dk[p] = mod_inv(ek[q + 5]);
                // middle additive pair is swapped except in the outermost group
                p--; dk[p] = (r < ROUNDS) ? -ek[q + 3] : -ek[q + 4];
                p--; dk[p] = (r < ROUNDS) ? -ek[q + 4] : -ek[q + 3];
                p--; dk[p] = mod_inv(ek[q + 2]);
                q += 6;
            end
            for (j = 0; j < SCHED; j++)
                subkeys[j] = dk[j];
        end
    endtask

    function automatic logic [BLK_W-1:0] idea_process(input logic [BLK_W-1:0] blk);
        logic [15:0] x1, x2, x3, x4, a, b, c, d, e, f, g;
        int          r;
        int          k;
        x1 = blk[15:0];
        x2 = blk[31:16];
        x3 = blk[47:32];
        x4 = blk[63:48];
        k  = 0;
        for (r = 0; r < ROUNDS; r++)
        begin
            a  = mod_mul(x1, subkeys[k]);
            b  = x2 + subkeys[k + 1];
            c  = x3 + subkeys[k + 2];
            d  = mod_mul(x4, subkeys[k + 3]);
            e  = mod_mul(a ^ c, subkeys[k + 4]);
            f  = mod_mul((b ^ d) + e, subkeys[k + 5]);
            g  = e + f;
            x1 = a ^ f;
            x2 = c ^ f;
            x3 = b ^ g;
            x4 = d ^ g;
            k += 6;
        end
        return {mod_mul(x4, subkeys[k + 3]), 16'(x2 + subkeys[k + 2]),
                16'(x3 + subkeys[k + 1]), mod_mul(x1, subkeys[k])};
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        logic [BLK_W-1:0] want;
        int               w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (cipher_q.size() == 0)
            begin
                $display("unexpected result beat %h at %0t", m_axis_tdata, $realtime);
                errors++;
            end
            else
            begin
                want = cipher_q.pop_front();
                for (w = 0; w < 4; w++)
                    if (m_axis_tdata[16*w +: 16] !== want[16*w +: 16])
                        report_mismatch($sformatf("result_word_%0d", w),
                                        m_axis_tdata[16*w +: 16], want[16*w +: 16]);
            end
        end
    end

    // receiver stall pattern plus counted long hold
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_cnt  = 400;
        end
        rx_phase++;
        if (rx_phase >= 64)
        begin
            rx_phase = 0;
            rx_mode  = $urandom_range(0, 3);
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 1);
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (rx_phase[3:0] < 4'd12);
            endcase
        end
    end

    task automatic send_block(input logic [BLK_W-1:0] blk);
        if (!no_idle && burst_left <= 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= blk;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        cipher_q.push_back(idea_process(blk));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (cipher_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CY) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_KEY_LOW)
            key_lo_m = val;
        else if (idx == REG_KEY_HIGH)
            key_hi_m = val;
        else if (idx == REG_MODE)
            decrypt_m = val[0];
        if (idx <= REG_MODE)
            rebuild_subkeys();
    endtask

    function automatic logic [BLK_W-1:0] rand_block();
        logic [BLK_W-1:0] v;
        int               w;
        v = {$urandom, $urandom};
        for (w = 0; w < 4; w++)
            case ($urandom_range(0, 9))
                0: v[16*w +: 16] = 16'h0000;
                1: v[16*w +: 16] = 16'hFFFF;
                2: v[16*w +: 16] = 16'h0001;
                default: ;
            endcase
        return v;
    endfunction

    function automatic logic [63:0] rand_key();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return '1;
            2: return {4{16'h0001}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_extremes();
        send_block('0);
        send_block('1);
        send_block({4{16'h0001}});
        send_block(64'h0000_FFFF_0000_FFFF);
        send_block(64'hFFFF_0000_FFFF_0000);
        send_block(64'h8000_0001_7FFF_FFFE);
    endtask

    task automatic test_reset_schedule();
        send_extremes();
    endtask

    task automatic test_encrypt_extremes();
        cfg_write(REG_MODE, 64'd0);
        send_extremes();
        cfg_write(REG_KEY_LOW, '1);
        cfg_write(REG_KEY_HIGH, '1);
        send_extremes();
    endtask

    task automatic test_decrypt_keyed();
        cfg_write(REG_KEY_LOW, 64'h0004_0003_0002_0001);
        cfg_write(REG_KEY_HIGH, 64'h0008_0007_0006_0005);
        // only bit 0 of the mode write counts
        cfg_write(REG_MODE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_extremes();
        cfg_write(REG_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
        send_block(64'h0003_0002_0001_0000);
    endtask

    task automatic test_unused_index();
        cfg_write(2'd3, '1);
        send_block(rand_block());
        send_block(rand_block());
    endtask

    task automatic test_backpressure();
        no_idle = 1'b1;
        hold_req++;
        repeat (12) send_block(rand_block());
        no_idle = 1'b0;
        // sender pauses until everything is back
        wait_drained();
        repeat (6) send_block(rand_block());
    endtask

    task automatic test_random();
        int ph;
        int n;
        for (ph = 0; ph < 8; ph++)
        begin
            case ($urandom_range(0, 3))
                0: cfg_write(REG_KEY_LOW, rand_key());
                1: cfg_write(REG_KEY_HIGH, rand_key());
                2: cfg_write(REG_MODE, {$urandom, $urandom});
                default:
                begin
                    cfg_write(REG_KEY_LOW, rand_key());
                    cfg_write(REG_KEY_HIGH, rand_key());
                end
            endcase
            no_idle = (ph == 3);
            for (n = 0; n < 100; n++)
                send_block(rand_block());
            no_idle = 1'b0;
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        errors        = 0;
        burst_left    = 0;
        no_idle       = 1'b0;
        hold_req      = 0;
        hold_seen     = 0;
        hold_cnt      = 0;
        rx_mode       = 0;
        rx_phase      = 0;
        key_lo_m      = '0;
        key_hi_m      = '0;
        decrypt_m     = 1'b1;
        rebuild_subkeys();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_schedule();
        test_encrypt_extremes();
        test_decrypt_keyed();
        test_unused_index();
        test_backpressure();
        test_random();

        wait_drained();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule
